// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL; they compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge of i_clk, ignored while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- src/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants for the system-exclusive template filler.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    // Default maximum message length.
    localparam int SFC_MAX_LEN = 256;

    // Token kinds carried with each template byte.
    localparam logic [4:0] KIND_KEEP      = 5'd0;
    localparam logic [4:0] KIND_BYTE      = 5'd1;
    localparam logic [4:0] KIND_CHAN      = 5'd2;
    localparam logic [4:0] KIND_CHAN_TAG  = 5'd3;
    localparam logic [4:0] KIND_LSB7      = 5'd4;
    localparam logic [4:0] KIND_MSB7      = 5'd5;
    localparam logic [4:0] KIND_LSB4      = 5'd6;
    localparam logic [4:0] KIND_MSB4      = 5'd7;
    localparam logic [4:0] KIND_COARSE    = 5'd8;
    localparam logic [4:0] KIND_FINE      = 5'd9;
    localparam logic [4:0] KIND_GLOBAL    = 5'd10;
    localparam logic [4:0] KIND_NIBBLE0   = 5'd11;
    localparam logic [4:0] KIND_NIBBLE1   = 5'd12;
    localparam logic [4:0] KIND_NIBBLE2   = 5'd13;
    localparam logic [4:0] KIND_NIBBLE3   = 5'd14;
    localparam logic [4:0] KIND_CSUM_TWOS = 5'd15;
    localparam logic [4:0] KIND_CSUM_ONES = 5'd16;
    localparam logic [4:0] KIND_CSUM_SUM  = 5'd17;
    localparam logic [4:0] KIND_CSUM_XOR  = 5'd18;
    localparam logic [4:0] KIND_XOR_RANGE = 5'd19;

    // Number of global slots.
    localparam int NUM_GLOBALS = 4;

    // Unset value of a global slot (minus one in 9 bits).
    localparam logic [8:0] GLOBAL_UNSET = 9'h1FF;

    // Payload of one accepted input item.
    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  template_byte;
        logic [15:0] value;
        logic [4:0]  channel;
        logic [7:0]  aux;
        logic        last;
    } t_item;

endpackage

`default_nettype wire

// ----- src/sfc_ram.sv -----
// ----------------------------------------------------------------------------
// sfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/sysex_template_fill_checksum_unit.sv -----
// Pipeline: two register stages, the input register and the result register; an item
// moves on into the result register once that register is free to take it.
// Throughput: one item per cycle unless the output stalls; the prefix stores need a
// single read each, issued at acceptance; running sum and XOR update per processed item.
// Reset: synchronous, active low; position, running sum and XOR, valid flags
// and global slots (set to unset) are cleared. The prefix stores need no clearing.
// ----------------------------------------------------------------------------
// sysex_template_fill_checksum_unit
// Fills a system-exclusive template byte by byte from the parameter value,
// channel and global slots, and inserts 7-bit checksums over recent bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sysex_template_fill_checksum_unit
    import sfc_pkg::*;
#(
    parameter int MAX_LEN = SFC_MAX_LEN
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [4:0]  i_kind,
    input  wire  [7:0]  i_template_byte,
    input  wire  [15:0] i_value,
    input  wire  [4:0]  i_channel,
    input  wire  [7:0]  i_aux,
    input  wire         i_last,
    // Output channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_overflow,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = (PW > 8) ? PW : 8;

    // Handshake and pipeline control.
    logic acc_in;
    logic advance;
    logic proc;

    // Accept-side position and window start.
    logic [PW-1:0] r_pos_a;
    logic [PW-1:0] n_pos_a;
    logic [CW-1:0] pos_w;
    logic [CW-1:0] aux_w;
    logic [CW-1:0] start_w;
    logic [PW-1:0] start_pos;
    logic          win_zero;
    logic          win_fwd;

    // Input register.
    logic          r_in_valid;
    t_item         r_in;
    logic [PW-1:0] r_pos;
    logic          r_zero;
    logic          r_fwd;

    // Running state.
    logic [7:0] r_sum;
    logic [7:0] r_xor;
    logic [7:0] n_sum;
    logic [7:0] n_xor;
    logic [7:0] r_wsum;
    logic [7:0] r_wxor;
    logic [7:0] r_x1;

    // Prefix store read data.
    logic [7:0] rd_sum;
    logic [7:0] rd_xor;

    // Global slots.
    logic [8:0] r_glob [NUM_GLOBALS];

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_ovf;

    // Item processing.
    logic       item_ovf;
    logic [3:0] chan;
    logic [7:0] mem_s;
    logic [7:0] mem_x;
    logic [7:0] win_s;
    logic [7:0] win_x;
    logic [8:0] glob_sel;
    logic [7:0] fill_byte;
    logic [7:0] b;

    // Handshake: the result register frees the input register.
    assign advance = !r_out_valid || !i_stall;
    assign proc    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign acc_in  = i_valid && !o_stall;

    // Window start, clamped to byte zero.
    assign pos_w   = CW'(r_pos_a);
    assign aux_w   = CW'(i_aux);
    assign start_w = pos_w - aux_w;
    always_comb begin
        if (aux_w > pos_w) begin
            start_pos = '0;
        end else begin
            start_pos = start_w[PW-1:0];
        end
    end
    // An empty window, or one at byte zero, sums to zero.
    assign win_zero = (i_aux == 8'd0) || (r_pos_a == '0);
    // The entry written by the item leaving the input register this cycle is
    // not yet in the store, so it is taken from the write data register.
    assign win_fwd  = proc && !win_zero && (start_pos == r_pos);

    // Next position for the following item.
    always_comb begin
        if (i_last) begin
            n_pos_a = '0;
        end else if (r_pos_a >= PW'(MAX_LEN)) begin
            n_pos_a = r_pos_a;
        end else begin
            n_pos_a = r_pos_a + 1'b1;
        end
    end

    // Prefix stores: written as each byte within the maximum length is processed, read at acceptance.
    sfc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_sum_store (
        .i_clk   (i_clk),
        .i_we    (proc && !item_ovf),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (r_sum),
        .i_re    (acc_in),
        .i_raddr (start_pos[AW-1:0]),
        .o_rdata (rd_sum)
    );

    sfc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_xor_store (
        .i_clk   (i_clk),
        .i_we    (proc && !item_ovf),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (r_xor),
        .i_re    (acc_in),
        .i_raddr (start_pos[AW-1:0]),
        .o_rdata (rd_xor)
    );

    // Window sum and XOR.
    assign item_ovf = (r_pos >= PW'(MAX_LEN));
    assign mem_s    = r_fwd ? r_wsum : rd_sum;
    assign mem_x    = r_fwd ? r_wxor : rd_xor;
    assign win_s    = r_zero ? 8'd0 : (r_sum - mem_s);
    assign win_x    = r_zero ? 8'd0 : (r_xor ^ mem_x);

    // Channel, one-based in, clamped to 0..15.
    always_comb begin
        if (r_in.channel == 5'd0) begin
            chan = 4'd0;
        end else if (r_in.channel > 5'd16) begin
            chan = 4'd15;
        end else begin
            chan = 4'(r_in.channel - 5'd1);
        end
    end

    assign glob_sel = r_glob[r_in.aux[1:0]];

    // Field selection by token kind.
    always_comb begin
        case (r_in.kind)
            KIND_BYTE:      fill_byte = r_in.value[7:0];
            KIND_CHAN:      fill_byte = {4'd0, chan};
            KIND_CHAN_TAG:  fill_byte = {1'b0, r_in.aux[2:0], chan};
            KIND_LSB7:      fill_byte = {1'b0, r_in.value[6:0]};
            KIND_MSB7:      fill_byte = {1'b0, r_in.value[13:7]};
            KIND_LSB4:      fill_byte = {4'd0, r_in.value[3:0]};
            KIND_MSB4:      fill_byte = {4'd0, r_in.value[7:4]};
            KIND_COARSE:    fill_byte = r_in.value[8:1];
            KIND_FINE:      fill_byte = {1'b0, r_in.value[0], 6'd0};
            KIND_GLOBAL: begin
                if (r_in.aux < 8'(NUM_GLOBALS) && !glob_sel[8]) begin
                    fill_byte = glob_sel[7:0];
                end else begin
                    fill_byte = r_in.template_byte;
                end
            end
            KIND_NIBBLE0:   fill_byte = {4'd0, r_in.value[3:0]};
            KIND_NIBBLE1:   fill_byte = {4'd0, r_in.value[7:4]};
            KIND_NIBBLE2:   fill_byte = {4'd0, r_in.value[11:8]};
            KIND_NIBBLE3:   fill_byte = {4'd0, r_in.value[15:12]};
            KIND_CSUM_TWOS: fill_byte = {1'b0, 7'(8'd0 - win_s)};
            KIND_CSUM_ONES: fill_byte = {1'b0, ~win_s[6:0]};
            KIND_CSUM_SUM:  fill_byte = {1'b0, win_s[6:0]};
            KIND_CSUM_XOR:  fill_byte = {1'b0, win_x[6:0]};
            KIND_XOR_RANGE: begin
                if (r_pos < PW'(2)) begin
                    fill_byte = r_in.template_byte;
                end else begin
                    fill_byte = r_xor ^ r_x1;
                end
            end
            default:        fill_byte = r_in.template_byte;
        endcase
    end

    // Overlong messages pass the template byte through.
    assign b = item_ovf ? r_in.template_byte : fill_byte;

    // Running sum and XOR after this byte.
    always_comb begin
        if (r_in.last) begin
            n_sum = 8'd0;
            n_xor = 8'd0;
        end else if (item_ovf) begin
            n_sum = r_sum;
            n_xor = r_xor;
        end else begin
            n_sum = r_sum + b;
            n_xor = r_xor ^ b;
        end
    end

    // Control state: position, valid flags, running values and globals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_a     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= 8'd0;
            r_xor       <= 8'd0;
            for (int g = 0; g < NUM_GLOBALS; g++) begin
                r_glob[g] <= GLOBAL_UNSET;
            end
        end else begin
            if (acc_in) begin
                r_pos_a <= n_pos_a;
            end
            if (acc_in) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
                r_sum       <= n_sum;
                r_xor       <= n_xor;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                r_glob[paddr[3:2]] <= pwdata[8:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_in.kind          <= i_kind;
            r_in.template_byte <= i_template_byte;
            r_in.value         <= i_value;
            r_in.channel       <= i_channel;
            r_in.aux           <= i_aux;
            r_in.last          <= i_last;
            r_pos              <= r_pos_a;
            r_zero             <= win_zero;
            r_fwd              <= win_fwd;
        end
        if (proc) begin
            r_wsum     <= r_sum;
            r_wxor     <= r_xor;
            r_out_byte <= b;
            r_out_last <= r_in.last;
            r_ovf      <= item_ovf;
            if (r_pos == '0) begin
                r_x1 <= b;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;
    assign o_overflow = r_ovf;

    // Configuration read-back, sign extended.
    assign pready = 1'b1;
    assign prdata = {{23{r_glob[paddr[3:2]][8]}}, r_glob[paddr[3:2]]};

    // Checks on the position and pipeline bookkeeping.
    `ASSERT_CLK(a_pos_bound, r_pos_a <= PW'(MAX_LEN), "position beyond maximum length")
    `ASSERT_NEXT(a_last_restart, acc_in && i_last, r_pos_a == '0, "position not restarted")
    `ASSERT_NEXT(a_ovf_flag, proc && item_ovf, o_valid && o_overflow, "overflow not flagged")
    `ASSERT_CLK(a_fwd_only_busy, !(acc_in && win_fwd) || r_in_valid, "forward without writer")

endmodule

`default_nettype wire

// ----- verif/sysex_fill_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_fill_checker
// Watches both item channels and the register port of the template filler.
// It predicts every output byte from the accepted input items and compares
// the accepted output items against those predictions in order.
// ----------------------------------------------------------------------------
module sysex_fill_checker
    import sfc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel as seen at the block
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [4:0]  i_kind,
    input  wire  [7:0]  i_template_byte,
    input  wire  [15:0] i_value,
    input  wire  [4:0]  i_channel,
    input  wire  [7:0]  i_aux,
    input  wire         i_last,
    // Output channel as seen at the block
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [7:0]  i_out_byte,
    input  wire         i_out_last,
    input  wire         i_overflow,
    // Register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    // Status towards the testbench top
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overflow;
    } t_sysex_byte;

    // Predicted bytes still waiting for their output item.
    t_sysex_byte expected_bytes[$];

    // Own copy of the message state and the global slots.
    logic [8:0] msg_pos;
    logic [7:0] sum_acc;
    logic [7:0] xor_acc;
    logic [7:0] sum_before [SFC_MAX_LEN];
    logic [7:0] xor_before [SFC_MAX_LEN];
    logic [8:0] global_slot [NUM_GLOBALS];
    int         mismatches = 0;

    // Byte that the block puts out at the current position for one item.
    function automatic logic [7:0] fill_byte(t_item it);
        logic [3:0] chan;
        logic [8:0] first;
        logic [7:0] wsum;
        logic [7:0] wxor;
        logic [7:0] wneg;
        if (it.channel == 5'd0) begin
            chan = 4'd0;
        end else if (it.channel > 5'd16) begin
            chan = 4'd15;
        end else begin
            chan = 4'(it.channel - 5'd1);
        end
        // The window is clamped at the first byte of the message.
        first = (9'(it.aux) > msg_pos) ? 9'd0 : msg_pos - 9'(it.aux);
        wsum  = sum_acc - sum_before[first[7:0]];
        wxor  = xor_acc ^ xor_before[first[7:0]];
        wneg  = 8'd0 - wsum;
        case (it.kind)
            KIND_BYTE:      return it.value[7:0];
            KIND_CHAN:      return {4'd0, chan};
            KIND_CHAN_TAG:  return {1'b0, it.aux[2:0], chan};
            KIND_LSB7:      return {1'b0, it.value[6:0]};
            KIND_MSB7:      return {1'b0, it.value[13:7]};
            KIND_LSB4:      return {4'd0, it.value[3:0]};
            KIND_MSB4:      return {4'd0, it.value[7:4]};
            KIND_COARSE:    return it.value[8:1];
            KIND_FINE:      return {1'b0, it.value[0], 6'd0};
            KIND_GLOBAL: begin
                // Slots past the last one and negative slots keep the template.
                if (it.aux < NUM_GLOBALS && !global_slot[it.aux[1:0]][8]) begin
                    return global_slot[it.aux[1:0]][7:0];
                end
                return it.template_byte;
            end
            KIND_NIBBLE0:   return {4'd0, it.value[3:0]};
            KIND_NIBBLE1:   return {4'd0, it.value[7:4]};
            KIND_NIBBLE2:   return {4'd0, it.value[11:8]};
            KIND_NIBBLE3:   return {4'd0, it.value[15:12]};
            KIND_CSUM_TWOS: return {1'b0, wneg[6:0]};
            KIND_CSUM_ONES: return {1'b0, ~wsum[6:0]};
            KIND_CSUM_SUM:  return {1'b0, wsum[6:0]};
            KIND_CSUM_XOR:  return {1'b0, wxor[6:0]};
            KIND_XOR_RANGE: begin
                // Needs at least two bytes behind it, else the template stays.
                if (msg_pos < 9'd2) begin
                    return it.template_byte;
                end
                return xor_acc ^ xor_before[1];
            end
            default:        return it.template_byte;
        endcase
    endfunction

    // Advance the message state by one accepted item and queue its result.
    task automatic predict_item(t_item it);
        t_sysex_byte want;
        want.out_last = it.last;
        if (msg_pos >= SFC_MAX_LEN) begin
            want.out_byte = it.template_byte;
            want.overflow = 1'b1;
        end else begin
            sum_before[msg_pos[7:0]] = sum_acc;
            xor_before[msg_pos[7:0]] = xor_acc;
            want.out_byte = fill_byte(it);
            want.overflow = 1'b0;
            sum_acc = sum_acc + want.out_byte;
            xor_acc = xor_acc ^ want.out_byte;
            msg_pos = msg_pos + 9'd1;
        end
        if (it.last) begin
            msg_pos = 9'd0;
            sum_acc = 8'd0;
            xor_acc = 8'd0;
        end
        expected_bytes.push_back(want);
    endtask

    // Compare one output item with the oldest prediction, field by field.
    task automatic check_byte(t_sysex_byte got);
        t_sysex_byte want;
        if (expected_bytes.size() == 0) begin
            $error("output item with nothing expected: out_byte %02h", got.out_byte);
            mismatches++;
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                mismatches++;
            end
        end
    endtask

    // Everything is sampled at the rising edge, before any update of this step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_pos = 9'd0;
            sum_acc = 8'd0;
            xor_acc = 8'd0;
            expected_bytes.delete();
            for (int s = 0; s < NUM_GLOBALS; s++) begin
                global_slot[s] = GLOBAL_UNSET;
            end
        end else begin
            if (psel && penable && pwrite && pready) begin
                global_slot[paddr[3:2]] = pwdata[8:0];
            end
            if (i_out_valid && !i_out_stall) begin
                check_byte({i_out_byte, i_out_last, i_overflow});
            end
            if (i_in_valid && !i_in_stall) begin
                predict_item({i_kind, i_template_byte, i_value, i_channel, i_aux, i_last});
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_bytes.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives system-exclusive templates through the template filler: a directed
// opening message, then random messages, noise and overlong messages under
// three idling patterns and several global slot settings. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sfc_pkg::*;

    localparam int         CLK_HALF     = 10;
    localparam int         RESET_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         PHASE_ITEMS  = 460;
    localparam logic [4:0] KIND_TOP     = 5'd31;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    wire         o_stall;
    logic [4:0]  i_kind          = '0;
    logic [7:0]  i_template_byte = '0;
    logic [15:0] i_value         = '0;
    logic [4:0]  i_channel       = '0;
    logic [7:0]  i_aux           = '0;
    logic        i_last          = 1'b0;
    wire         o_valid;
    logic        i_stall         = 1'b0;
    wire [7:0]   o_out_byte;
    wire         o_out_last;
    wire         o_overflow;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    wire [31:0]  prdata;
    wire         pready;

    wire [31:0]  mismatch_count;
    wire [31:0]  outstanding;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    logic        hold_req           = 1'b0;
    logic        hold_taken         = 1'b0;
    int          hold_left          = 0;
    int          cycle_count        = 0;
    int          items_sent         = 0;

    sysex_template_fill_checksum_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_template_byte (i_template_byte),
        .i_value         (i_value),
        .i_channel       (i_channel),
        .i_aux           (i_aux),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_overflow      (o_overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    sysex_fill_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_kind          (i_kind),
        .i_template_byte (i_template_byte),
        .i_value         (i_value),
        .i_channel       (i_channel),
        .i_aux           (i_aux),
        .i_last          (i_last),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_out_last      (o_out_last),
        .i_overflow      (o_overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_mismatches    (mismatch_count),
        .o_outstanding   (outstanding)
    );

    // Free-running clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stalls: random, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    function automatic t_item make_item(logic [4:0] kind, logic [7:0] tb, logic [15:0] val,
                                        logic [4:0] ch, logic [7:0] aux, logic last);
        t_item it;
        it.kind          = kind;
        it.template_byte = tb;
        it.value         = val;
        it.channel       = ch;
        it.aux           = aux;
        it.last          = last;
        return it;
    endfunction

    // Random item for a given position in its message; last is left low.
    function automatic t_item random_item(int pos);
        t_item it;
        if ($urandom_range(15) == 0) begin
            it.kind = 5'($urandom_range(KIND_TOP, KIND_XOR_RANGE + 1));
        end else begin
            it.kind = 5'($urandom_range(KIND_XOR_RANGE));
        end
        it.template_byte = 8'($urandom);
        case ($urandom_range(7))
            0:       it.value = 16'h0000;
            1:       it.value = 16'hFFFF;
            default: it.value = 16'($urandom);
        endcase
        if ($urandom_range(3) == 0) begin
            it.channel = 5'($urandom);
        end else begin
            it.channel = 5'($urandom_range(16, 1));
        end
        if (it.kind >= KIND_CSUM_TWOS && it.kind <= KIND_CSUM_XOR) begin
            // Half the time windows inside the message, else any width, which may reach before it.
            it.aux = ($urandom_range(1) == 0) ? 8'($urandom_range(pos + 1)) : 8'($urandom);
        end else if (it.kind == KIND_GLOBAL) begin
            it.aux = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        end else begin
            it.aux = 8'($urandom);
        end
        it.last = 1'b0;
        return it;
    endfunction

    // Offer one item, after an optional random gap, and wait for acceptance.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= it.kind;
        i_template_byte <= it.template_byte;
        i_value         <= it.value;
        i_channel       <= it.channel;
        i_aux           <= it.aux;
        i_last          <= it.last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Stop offering and wait until every predicted byte has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Back-to-back register writes to all global slots.
    task automatic program_globals(logic [8:0] g0, logic [8:0] g1,
                                   logic [8:0] g2, logic [8:0] g3);
        logic [8:0] vals [NUM_GLOBALS];
        vals[0] = g0;
        vals[1] = g1;
        vals[2] = g2;
        vals[3] = g3;
        for (int s = 0; s < NUM_GLOBALS; s++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(s * 4);
            pwdata  <= {{23{vals[s][8]}}, vals[s]};
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) begin
                @(posedge i_clk);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A message: start byte, random body, often a checksum, usually an end byte.
    task automatic send_message(int len);
        t_item it;
        it = random_item(0);
        it.kind = KIND_KEEP;
        it.template_byte = SYSEX_START;
        send_item(it);
        for (int pos = 1; pos < len - 1; pos++) begin
            it = random_item(pos);
            if (pos == len - 2 && $urandom_range(1) == 0) begin
                it.kind = 5'($urandom_range(KIND_XOR_RANGE, KIND_CSUM_TWOS));
            end
            send_item(it);
        end
        it = random_item(len - 1);
        if ($urandom_range(3) != 0) begin
            it.kind = KIND_KEEP;
            it.template_byte = SYSEX_END;
        end
        it.last = 1'b1;
        send_item(it);
    endtask

    // Unstructured items with the end flag at random.
    task automatic send_noise(int count);
        t_item it;
        for (int n = 0; n < count; n++) begin
            it = random_item($urandom_range(255));
            it.last = ($urandom_range(5) == 0);
            send_item(it);
        end
    endtask

    // One phase of random traffic with optional long message, pause and hold-off.
    task automatic run_phase(bit with_long, bit with_pause, bit with_hold);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) begin
            if (with_pause && items_sent - first_item >= PHASE_ITEMS / 2) begin
                drain_results();
                with_pause = 1'b0;
            end
            if (with_hold && items_sent - first_item >= PHASE_ITEMS / 3) begin
                hold_req  <= 1'b1;
                with_hold = 1'b0;
            end
            if (with_long && items_sent - first_item >= PHASE_ITEMS / 4) begin
                // Runs past the maximum length so the overflow path is taken.
                send_message($urandom_range(300, SFC_MAX_LEN + 2));
                with_long = 1'b0;
            end else if ($urandom_range(7) == 0) begin
                send_noise($urandom_range(12, 1));
            end else begin
                send_message($urandom_range(24, 2));
            end
        end
        drain_results();
    endtask

    // Stimulus and verdict.
    initial begin
        t_item opening[$];
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Opening message with the global slots still unset from reset.
        opening.push_back(make_item(KIND_XOR_RANGE, SYSEX_START, 16'h0000, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_XOR_RANGE, 8'h41, 16'h0000, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_BYTE, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_CHAN, 8'hFF, 16'h0000, 5'd0, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_CHAN, 8'h00, 16'h0000, 5'd16, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_CHAN, 8'h00, 16'h0000, 5'd31, 8'hFF, 1'b0));
        opening.push_back(make_item(KIND_CHAN_TAG, 8'h00, 16'h0000, 5'd1, 8'hFF, 1'b0));
        opening.push_back(make_item(KIND_LSB7, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_MSB7, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_LSB4, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_MSB4, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_COARSE, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_FINE, 8'h00, 16'hFFFF, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_GLOBAL, 8'h5A, 16'h0000, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_GLOBAL, 8'hA5, 16'h0000, 5'd1, 8'hFF, 1'b0));
        opening.push_back(make_item(KIND_NIBBLE0, 8'h00, 16'h1234, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_NIBBLE1, 8'h00, 16'h1234, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_NIBBLE2, 8'h00, 16'h1234, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_NIBBLE3, 8'h00, 16'hFEDC, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_CSUM_TWOS, 8'h00, 16'h0000, 5'd1, 8'hFF, 1'b0));
        opening.push_back(make_item(KIND_CSUM_ONES, 8'h00, 16'h0000, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_CSUM_SUM, 8'h00, 16'h0000, 5'd1, 8'h05, 1'b0));
        opening.push_back(make_item(KIND_CSUM_XOR, 8'h00, 16'h0000, 5'd1, 8'h03, 1'b0));
        opening.push_back(make_item(KIND_XOR_RANGE, 8'h00, 16'h0000, 5'd1, 8'h00, 1'b0));
        opening.push_back(make_item(KIND_TOP, SYSEX_END, 16'hFFFF, 5'd1, 8'hFF, 1'b1));
        foreach (opening[k]) begin
            send_item(opening[k]);
        end
        drain_results();

        // Sender idles lightly, receiver stalls heavily.
        program_globals(9'd0, 9'd255, GLOBAL_UNSET, 9'd127);
        sender_idle_pct     = 14;
        receiver_stall_pct <= 54;
        run_phase(1'b1, 1'b1, 1'b0);

        // Roles swapped.
        program_globals(9'd255, 9'd0, 9'd128, GLOBAL_UNSET);
        sender_idle_pct     = 54;
        receiver_stall_pct <= 14;
        run_phase(1'b0, 1'b0, 1'b0);

        // No idling at all, random slot values, one long receiver hold-off.
        program_globals(9'($urandom_range(256) - 1), 9'($urandom_range(256) - 1),
                        9'($urandom_range(256) - 1), 9'($urandom_range(256) - 1));
        sender_idle_pct     = 0;
        receiver_stall_pct <= 0;
        run_phase(1'b1, 1'b0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
